/* rtl/srvb_pkg.sv */
`timescale 1ns / 1ps
// Package for the servo bus packet engine: request codes, frame constants,
// receive store sizing and the transmit frame byte table. No dependencies.
package srvb_pkg;

    localparam int RX_DEPTH = 32;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int RX_CW    = RX_AW + 1;

    localparam logic [7:0] HDR_BYTE         = 8'hFF;
    localparam logic [7:0] INSTR_READ       = 8'h02;
    localparam logic [7:0] INSTR_WRITE      = 8'h03;
    localparam logic [7:0] ADDR_GOAL_POS    = 8'd42;
    localparam logic [7:0] ADDR_TORQUE_EN   = 8'd40;
    localparam logic [7:0] ADDR_TORQUE_LIM  = 8'd34;
    localparam logic [7:0] ADDR_PRESENT_POS = 8'd56;
    localparam logic [7:0] READ_LEN         = 8'd2;

    localparam logic KIND_TX  = 1'b0;
    localparam logic KIND_POS = 1'b1;

    typedef enum logic [2:0] {
        REQ_READ_POS   = 3'd0,
        REQ_WRITE_POS  = 3'd1,
        REQ_TORQUE_OFF = 3'd2,
        REQ_TORQUE_ON  = 3'd3,
        REQ_TORQUE_LIM = 3'd4,
        REQ_RX_BYTE    = 3'd5,
        REQ_BURST_END  = 3'd6
    } t_req;

    // value of the length field of each command frame
    function automatic logic [7:0] len_field(t_req kind);
        logic [7:0] l;
        l = 8'd4;
        case (kind)
            REQ_WRITE_POS:  l = 8'd9;
            REQ_TORQUE_LIM: l = 8'd5;
            default:        l = 8'd4;
        endcase
        return l;
    endfunction

    // index of the checksum byte (frame length minus one)
    function automatic logic [3:0] last_idx(t_req kind);
        logic [7:0] l;
        l = len_field(kind) + 8'd3;
        return l[3:0];
    endfunction

    // frame byte at idx, checksum excluded
    function automatic logic [7:0] frame_byte(t_req kind, logic [3:0] idx,
                                              logic [7:0] id, logic [15:0] gpos,
                                              logic [15:0] spd, logic [15:0] lim);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            4'd0, 4'd1: b = HDR_BYTE;
            4'd2:       b = id;
            4'd3:       b = len_field(kind);
            4'd4:       b = (kind == REQ_READ_POS) ? INSTR_READ : INSTR_WRITE;
            default: begin
                case (kind)
                    REQ_READ_POS: begin
                        case (idx)
                            4'd5:    b = ADDR_PRESENT_POS;
                            4'd6:    b = READ_LEN;
                            default: b = 8'h00;
                        endcase
                    end
                    REQ_WRITE_POS: begin
                        case (idx)
                            4'd5:    b = ADDR_GOAL_POS;
                            4'd6:    b = gpos[7:0];
                            4'd7:    b = gpos[15:8];
                            4'd10:   b = spd[7:0];
                            4'd11:   b = spd[15:8];
                            default: b = 8'h00;
                        endcase
                    end
                    REQ_TORQUE_OFF, REQ_TORQUE_ON: begin
                        case (idx)
                            4'd5:    b = ADDR_TORQUE_EN;
                            4'd6:    b = (kind == REQ_TORQUE_ON) ? 8'h01 : 8'h00;
                            default: b = 8'h00;
                        endcase
                    end
                    REQ_TORQUE_LIM: begin
                        case (idx)
                            4'd5:    b = ADDR_TORQUE_LIM;
                            4'd6:    b = lim[7:0];
                            4'd7:    b = lim[15:8];
                            default: b = 8'h00;
                        endcase
                    end
                    default: b = 8'h00;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

/* rtl/servo_bus_packet_engine.sv */
`timescale 1ns / 1ps
// Servo bus packet engine: builds command frames byte by byte, stores
// received bytes and scans them for a position reply. Uses srvb_pkg.
//
// Command: one frame byte per cycle unless the output stalls; the first byte
//   is registered after the engine enters its transmit state. Frame length
//   is 8, 9 or 13 bytes. Received byte: stored while the store has room.
// Burst end: the store is read one byte a cycle through a 7-byte window.
// Reset clears control state, byte count and expected id; the store is not
//   cleared (only written entries are ever read).
module servo_bus_packet_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_req_type,
    input  logic [7:0]          i_servo_id,
    input  logic signed [15:0]  i_goal_position,
    input  logic [15:0]         i_speed,
    input  logic [15:0]         i_torque_limit,
    input  logic [7:0]          i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_out_kind,
    output logic [7:0]          o_tx_byte,
    output logic                o_tx_last,
    output logic                o_found,
    output logic signed [15:0]  o_position
);
    import srvb_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_TX, ST_SCAN, ST_RPT} t_state;

    t_state             r_state;
    t_req               r_kind;
    logic [7:0]         r_id;
    logic [15:0]        r_gpos, r_spd, r_lim;
    logic [3:0]         r_idx;
    logic [7:0]         r_sum;
    logic [RX_CW-1:0]   r_rx_count;
    logic [7:0]         r_exp_id;

    logic [7:0]         r_mem [RX_DEPTH];
    logic [RX_CW-1:0]   r_rd_ptr;
    logic               r_rd_vld;
    logic [7:0]         r_rd_data;
    logic [7:0]         r_win [7];
    logic [RX_CW-1:0]   r_win_n;
    logic               r_win_new;
    logic               r_found;
    logic [15:0]        r_pos;

    logic               r_out_valid;
    logic               r_out_kind;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_found;
    logic [15:0]        r_out_pos;

    logic               accept, slot_free, tx_last, rd_en, mem_we, win_hit;
    t_req               req;
    logic [7:0]         tx_data;
    logic [9:0]         frame_end, avail;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign req         = t_req'(i_req_type);
    assign slot_free   = !r_out_valid || i_out_ready;
    assign tx_last     = (r_idx == last_idx(r_kind));
    assign tx_data     = frame_byte(r_kind, r_idx, r_id, r_gpos, r_spd, r_lim);
    assign rd_en       = (r_state == ST_SCAN) && (r_rd_ptr != r_rx_count);
    assign mem_we      = accept && (req == REQ_RX_BYTE) && (r_rx_count < RX_CW'(RX_DEPTH));

    // window holds bytes i..i+6 with i = win_n - 7; all frame bytes but the
    // checksum are stored if i + 3 + len <= count, i.e. win_n + len <= count + 4
    assign frame_end = 10'(r_win_n) + 10'(r_win[3]);
    assign avail     = 10'(r_rx_count) + 10'd4;
    assign win_hit   = r_win_new && (r_win[0] == HDR_BYTE) && (r_win[1] == HDR_BYTE) &&
                       (r_win[2] == r_exp_id) && (r_win[3] >= 8'd4) &&
                       (frame_end <= avail);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_rx_count[RX_AW-1:0]] <= i_rx_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr[RX_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rx_count  <= '0;
            r_exp_id    <= 8'h00;
            r_rd_vld    <= 1'b0;
            r_win_new   <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_kind <= req;
                        r_id   <= i_servo_id;
                        r_gpos <= i_goal_position;
                        r_spd  <= i_speed;
                        r_lim  <= i_torque_limit;
                        r_idx  <= 4'd0;
                        r_sum  <= 8'h00;
                        case (req)
                            REQ_READ_POS: begin
                                r_rx_count <= '0;
                                r_exp_id   <= i_servo_id;
                                r_state    <= ST_TX;
                            end
                            REQ_WRITE_POS, REQ_TORQUE_OFF, REQ_TORQUE_ON,
                            REQ_TORQUE_LIM: begin
                                r_state <= ST_TX;
                            end
                            REQ_RX_BYTE: begin
                                if (mem_we) begin
                                    r_rx_count <= r_rx_count + 1'b1;
                                end
                            end
                            REQ_BURST_END: begin
                                r_rd_ptr  <= '0;
                                r_win_n   <= '0;
                                r_rd_vld  <= 1'b0;
                                r_win_new <= 1'b0;
                                r_state   <= ST_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_TX: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_TX;
                        r_out_byte  <= tx_last ? ~r_sum : tx_data;
                        r_out_last  <= tx_last;
                        r_out_found <= 1'b0;
                        r_out_pos   <= 16'h0000;
                        if (tx_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 4'd1;
                            if (r_idx >= 4'd2) begin
                                r_sum <= r_sum + tx_data;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    r_rd_vld  <= rd_en;
                    r_win_new <= 1'b0;
                    if (rd_en) begin
                        r_rd_ptr <= r_rd_ptr + 1'b1;
                    end
                    if (r_rd_vld) begin
                        for (int k = 0; k < 6; k++) begin
                            r_win[k] <= r_win[k+1];
                        end
                        r_win[6]  <= r_rd_data;
                        r_win_n   <= r_win_n + 1'b1;
                        r_win_new <= (r_win_n >= RX_CW'(6));
                    end
                    if (win_hit) begin
                        r_found <= 1'b1;
                        r_pos   <= {r_win[6], r_win[5]};
                        r_state <= ST_RPT;
                    end else if (!rd_en && !r_rd_vld && !r_win_new) begin
                        r_found <= 1'b0;
                        r_pos   <= 16'hFFFF;
                        r_state <= ST_RPT;
                    end
                end
                ST_RPT: begin
                    r_rd_vld  <= 1'b0;
                    r_win_new <= 1'b0;
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_POS;
                        r_out_byte  <= 8'h00;
                        r_out_last  <= 1'b0;
                        r_out_found <= r_found;
                        r_out_pos   <= r_pos;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_tx_byte   = r_out_byte;
    assign o_tx_last   = r_out_last;
    assign o_found     = r_out_found;
    assign o_position  = r_out_pos;

endmodule
